[hdl/gbe_pkg.sv]
// gbe_pkg: shared constants for the gap buffer line editor
// command codes, status codes and field widths; no dependencies
package gbe_pkg;

  // default store size in bytes
  localparam int CAPACITY_DEF = 256;

  // field widths
  localparam int FUNC_W = 4;
  localparam int CH_W   = 8;
  localparam int POS_W  = 9;
  localparam int STAT_W = 2;

  // command codes
  localparam logic [FUNC_W-1:0] FN_INSERT    = 4'd0;
  localparam logic [FUNC_W-1:0] FN_BACKSPACE = 4'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE    = 4'd2;
  localparam logic [FUNC_W-1:0] FN_LEFT      = 4'd3;
  localparam logic [FUNC_W-1:0] FN_RIGHT     = 4'd4;
  localparam logic [FUNC_W-1:0] FN_HOME      = 4'd5;
  localparam logic [FUNC_W-1:0] FN_END       = 4'd6;
  localparam logic [FUNC_W-1:0] FN_SETCUR    = 4'd7;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 4'd8;
  localparam logic [FUNC_W-1:0] FN_READ      = 4'd9;

  // first and last of the spare command codes, answered with no change
  localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 4'd10;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 4'd15;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

endpackage

[hdl/gbe_store.sv]
// gbe_store: byte store of the gap buffer, one write and one read port
// read data registered; depends on gbe_pkg for the byte width
module gbe_store #(
  parameter int DEPTH = gbe_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [gbe_pkg::CH_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic [gbe_pkg::CH_W-1:0] rdata
);

  logic [gbe_pkg::CH_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/gap_buffer_line_editor_core.sv]
// gap_buffer_line_editor_core: top level of the gap buffer line editor
// sequencer and gap pointers; depends on gbe_pkg and gbe_store
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_func, in_ch, in_position
//   out_     output     out_valid/out_ready  out_status, out_cursor,
//                                            out_text_length, out_ch_out
//
// a request passes from acceptance through S_EXEC and S_FIN to the result register
// for insert, backspace, delete, clear, no-op codes, a refused read or set cursor,
// and left or right at the end of the line; a read in range adds S_RDATA, and cursor
// moves add an S_MOVE and S_SHIFT pass for each byte carried across the gap (one store read
// and one store write per byte through the single store port pair); home, end
// and set cursor may carry up to CAPACITY bytes.
// reset clears the pointers and control; the store holds no reset.
// in_ready is high only while no request is in work; a result waiting on
// out_ready holds the next request at its final step.
module gap_buffer_line_editor_core #(
  parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gbe_pkg::FUNC_W-1:0]  in_func,
  input  logic [gbe_pkg::CH_W-1:0]    in_ch,
  input  logic [gbe_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gbe_pkg::STAT_W-1:0]  out_status,
  output logic [gbe_pkg::POS_W-1:0]   out_cursor,
  output logic [gbe_pkg::POS_W-1:0]   out_text_length,
  output logic [gbe_pkg::CH_W-1:0]    out_ch_out
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = (PW > gbe_pkg::POS_W) ? PW : gbe_pkg::POS_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_SHIFT,
    S_RDATA,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [gbe_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [gbe_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [gbe_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]              gs_r, gs_nxt;
  logic [PW-1:0]              ge_r, ge_nxt;
  logic [PW-1:0]              target_r, target_nxt;
  logic                       left_r, left_nxt;
  logic [gbe_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [gbe_pkg::CH_W-1:0]   rd_r, rd_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [gbe_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [gbe_pkg::POS_W-1:0]   out_cursor_r, out_cursor_nxt;
  logic [gbe_pkg::POS_W-1:0]   out_len_r, out_len_nxt;
  logic [gbe_pkg::CH_W-1:0]    out_ch_r, out_ch_nxt;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [gbe_pkg::CH_W-1:0]    mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [gbe_pkg::CH_W-1:0]    mem_rdata;

  logic [PW-1:0] cur_len;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] gs_ext;
  logic [CW-1:0] read_idx;
  logic [PW-1:0] gs_dec;
  logic [PW-1:0] ge_dec;

  gbe_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // text length and widened operands for the position compares
  assign cur_len  = gs_r + (CAP_P - ge_r);
  assign len_ext  = CW'(cur_len);
  assign pos_ext  = CW'(pos_r);
  assign gs_ext   = CW'(gs_r);
  assign gs_dec   = gs_r - ONE_P;
  assign ge_dec   = ge_r - ONE_P;
  // logical position to store index: skip the gap when past the cursor
  assign read_idx = (pos_ext < gs_ext) ? pos_ext : (pos_ext + CW'(ge_r - gs_r));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    ch_nxt         = ch_r;
    pos_nxt        = pos_r;
    gs_nxt         = gs_r;
    ge_nxt         = ge_r;
    target_nxt     = target_r;
    left_nxt       = left_r;
    status_nxt     = status_r;
    rd_nxt         = rd_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_cursor_nxt = out_cursor_r;
    out_len_nxt    = out_len_r;
    out_ch_nxt     = out_ch_r;
    mem_we         = 1'b0;
    mem_waddr      = gs_r[AW-1:0];
    mem_wdata      = ch_r;
    mem_raddr      = gs_dec[AW-1:0];

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          ch_nxt    = in_ch;
          pos_nxt   = in_position;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = gbe_pkg::ST_OK;
        rd_nxt     = '0;
        state_nxt  = S_FIN;
        mem_raddr  = read_idx[AW-1:0];
        case (func_r)
          gbe_pkg::FN_INSERT: begin
            if (gs_r < ge_r) begin
              mem_we    = 1'b1;
              mem_waddr = gs_r[AW-1:0];
              mem_wdata = ch_r;
              gs_nxt    = gs_r + ONE_P;
            end else begin
              status_nxt = gbe_pkg::ST_FULL;
            end
          end
          gbe_pkg::FN_BACKSPACE: begin
            if (gs_r != '0) gs_nxt = gs_dec;
          end
          gbe_pkg::FN_DELETE: begin
            if (ge_r != CAP_P) ge_nxt = ge_r + ONE_P;
          end
          gbe_pkg::FN_LEFT: begin
            if (gs_r != '0) begin
              target_nxt = gs_dec;
              state_nxt  = S_MOVE;
            end
          end
          gbe_pkg::FN_RIGHT: begin
            if (ge_r != CAP_P) begin
              target_nxt = gs_r + ONE_P;
              state_nxt  = S_MOVE;
            end
          end
          gbe_pkg::FN_HOME: begin
            target_nxt = '0;
            state_nxt  = S_MOVE;
          end
          gbe_pkg::FN_END: begin
            target_nxt = cur_len;
            state_nxt  = S_MOVE;
          end
          gbe_pkg::FN_SETCUR: begin
            if (pos_ext > len_ext) begin
              status_nxt = gbe_pkg::ST_BADPOS;
            end else begin
              target_nxt = PW'(pos_ext);
              state_nxt  = S_MOVE;
            end
          end
          gbe_pkg::FN_CLEAR: begin
            gs_nxt = '0;
            ge_nxt = CAP_P;
          end
          gbe_pkg::FN_READ: begin
            if (pos_ext >= len_ext) begin
              status_nxt = gbe_pkg::ST_BADPOS;
            end else begin
              state_nxt = S_RDATA;
            end
          end
          default: begin
          end
        endcase
      end

      // pick the direction of the next byte carried across the gap
      S_MOVE: begin
        if (gs_r > target_r) begin
          mem_raddr = gs_dec[AW-1:0];
          left_nxt  = 1'b1;
          state_nxt = S_SHIFT;
        end else if (gs_r < target_r && ge_r != CAP_P) begin
          mem_raddr = ge_r[AW-1:0];
          left_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // write the byte on the far side of the gap and slide the pointers
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (left_r) begin
          mem_waddr = ge_dec[AW-1:0];
          gs_nxt    = gs_dec;
          ge_nxt    = ge_dec;
        end else begin
          mem_waddr = gs_r[AW-1:0];
          gs_nxt    = gs_r + ONE_P;
          ge_nxt    = ge_r + ONE_P;
        end
        state_nxt = S_MOVE;
      end

      S_RDATA: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_FIN;
      end

      // load the result register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_cursor_nxt = gs_ext[gbe_pkg::POS_W-1:0];
          out_len_nxt    = len_ext[gbe_pkg::POS_W-1:0];
          out_ch_nxt     = rd_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gs_r        <= '0;
      ge_r        <= CAP_P;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    ch_r         <= ch_nxt;
    pos_r        <= pos_nxt;
    target_r     <= target_nxt;
    left_r       <= left_nxt;
    status_r     <= status_nxt;
    rd_r         <= rd_nxt;
    out_status_r <= out_status_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_len_r    <= out_len_nxt;
    out_ch_r     <= out_ch_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_cursor      = out_cursor_r;
  assign out_text_length = out_len_r;
  assign out_ch_out      = out_ch_r;

endmodule

[hdl/gbe_checker.sv]
// gbe_checker: port-level checks for the gap buffer line editor
// bound to gap_buffer_line_editor_core; depends on gbe_pkg
module gbe_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [gbe_pkg::FUNC_W-1:0] in_func,
  input logic [gbe_pkg::CH_W-1:0]   in_ch,
  input logic [gbe_pkg::POS_W-1:0]  in_position,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gbe_pkg::STAT_W-1:0] out_status,
  input logic [gbe_pkg::POS_W-1:0]  out_cursor,
  input logic [gbe_pkg::POS_W-1:0]  out_text_length,
  input logic [gbe_pkg::CH_W-1:0]   out_ch_out
);

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_cursor) && $stable(out_text_length) && $stable(out_ch_out))
    else $error("result changed while stalled");

  // a waiting request keeps its contents
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_func) &&
    $stable(in_ch) && $stable(in_position))
    else $error("request changed while waiting");

  // one request in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // a failed request returns no character
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gbe_pkg::ST_OK |-> out_ch_out == '0)
    else $error("character returned on failed request");

  // status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == gbe_pkg::ST_OK || out_status == gbe_pkg::ST_FULL ||
    out_status == gbe_pkg::ST_BADPOS)
    else $error("undefined status code");

endmodule

bind gap_buffer_line_editor_core gbe_checker u_gbe_checker (.*);

[bench/tb_gap_buffer_line_editor_core.sv]
// tb_gap_buffer_line_editor_core: self-checking bench for the gap buffer line editor
// drives edit requests under random flow control and checks every reply against
// a gap-buffer predictor; depends on gbe_pkg and gap_buffer_line_editor_core
module tb_gap_buffer_line_editor_core;

  localparam int CAP        = gbe_pkg::CAPACITY_DEF;
  localparam int FUNC_W     = gbe_pkg::FUNC_W;
  localparam int CH_W       = gbe_pkg::CH_W;
  localparam int POS_W      = gbe_pkg::POS_W;
  localparam int STAT_W     = gbe_pkg::STAT_W;
  localparam int IDLE_LIMIT = 8 * CAP + 600;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_AFTER = 400;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CH_W-1:0]   ch;
    logic [POS_W-1:0]  position;
  } edit_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  text_length;
    logic [CH_W-1:0]   ch_out;
  } edit_reply_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func     = '0;
  logic [CH_W-1:0]   in_ch       = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [POS_W-1:0]  out_cursor;
  logic [POS_W-1:0]  out_text_length;
  logic [CH_W-1:0]   out_ch_out;

  gap_buffer_line_editor_core #(.CAPACITY(CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_ch           (in_ch),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_cursor      (out_cursor),
    .out_text_length (out_text_length),
    .out_ch_out      (out_ch_out)
  );

  // predictor state: byte store and gap pointers
  logic [CH_W-1:0]  line_buf [CAP];
  logic [POS_W-1:0] gap_lo = '0;
  logic [POS_W-1:0] gap_hi = POS_W'(CAP);

  edit_cmd_t   cmd_backlog[$];
  edit_reply_t awaited_replies[$];

  int n_fail     = 0;
  int n_cmds     = 0;
  int n_replies  = 0;
  int n_full     = 0;
  int n_badpos   = 0;
  int n_reads    = 0;
  int peak_len   = 0;
  int burst_left = 1;
  int gap_left   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int line_len();
    return int'(gap_lo) + CAP - int'(gap_hi);
  endfunction

  // carry bytes across the gap until the cursor sits at target
  task automatic slide_gap(input int target);
    while (int'(gap_lo) > target) begin
      gap_lo--;
      gap_hi--;
      line_buf[gap_hi] = line_buf[gap_lo];
    end
    while (int'(gap_lo) < target && int'(gap_hi) < CAP) begin
      line_buf[gap_lo] = line_buf[gap_hi];
      gap_lo++;
      gap_hi++;
    end
  endtask

  // apply one edit request to the predictor and form its reply
  task automatic edit_line(input edit_cmd_t c, output edit_reply_t r);
    int idx;
    r = '0;
    r.status = gbe_pkg::ST_OK;
    case (c.func)
      gbe_pkg::FN_INSERT: begin
        if (gap_lo < gap_hi) begin
          line_buf[gap_lo] = c.ch;
          gap_lo++;
        end else begin
          r.status = gbe_pkg::ST_FULL;
          n_full++;
        end
      end
      gbe_pkg::FN_BACKSPACE: if (gap_lo > 0) gap_lo--;
      gbe_pkg::FN_DELETE:    if (int'(gap_hi) < CAP) gap_hi++;
      gbe_pkg::FN_LEFT:      if (gap_lo > 0) slide_gap(int'(gap_lo) - 1);
      gbe_pkg::FN_RIGHT:     if (int'(gap_hi) < CAP) slide_gap(int'(gap_lo) + 1);
      gbe_pkg::FN_HOME:      slide_gap(0);
      gbe_pkg::FN_END:       slide_gap(line_len());
      gbe_pkg::FN_SETCUR: begin
        if (int'(c.position) > line_len()) begin
          r.status = gbe_pkg::ST_BADPOS;
          n_badpos++;
        end else begin
          slide_gap(int'(c.position));
        end
      end
      gbe_pkg::FN_CLEAR: begin
        gap_lo = '0;
        gap_hi = POS_W'(CAP);
      end
      gbe_pkg::FN_READ: begin
        if (int'(c.position) >= line_len()) begin
          r.status = gbe_pkg::ST_BADPOS;
          n_badpos++;
        end else begin
          idx = (c.position < gap_lo) ? int'(c.position)
                                      : int'(c.position) + int'(gap_hi) - int'(gap_lo);
          r.ch_out = line_buf[idx];
          n_reads++;
        end
      end
      default: ;
    endcase
    r.cursor      = gap_lo;
    r.text_length = POS_W'(line_len());
    if (line_len() > peak_len) peak_len = line_len();
  endtask

  function automatic edit_cmd_t cmd_of(input logic [FUNC_W-1:0] f,
                                       input int c, input int p);
    edit_cmd_t e;
    e.func     = f;
    e.ch       = CH_W'(c);
    e.position = POS_W'(p);
    return e;
  endfunction

  // random request; insert_pct weights inserts, growing drops shrinking commands
  function automatic edit_cmd_t random_cmd(input int insert_pct, input bit growing);
    edit_cmd_t e;
    int        pick;
    e.ch = CH_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 50)      e.position = POS_W'($urandom_range(0, 15));
    else if (pick < 85) e.position = POS_W'($urandom_range(0, CAP));
    else                e.position = POS_W'($urandom_range(0, 511));
    if ($urandom_range(0, 99) < insert_pct) begin
      e.func = gbe_pkg::FN_INSERT;
    end else if ($urandom_range(0, 19) < 2) begin
      e.func = FUNC_W'($urandom_range(int'(gbe_pkg::FN_SPARE_LO),
                                      int'(gbe_pkg::FN_SPARE_HI)));
    end else begin
      e.func = FUNC_W'($urandom_range(int'(gbe_pkg::FN_BACKSPACE),
                                      int'(gbe_pkg::FN_READ)));
      if (e.func == gbe_pkg::FN_CLEAR && $urandom_range(0, 7) != 0)
        e.func = gbe_pkg::FN_READ;
      if (growing && (e.func == gbe_pkg::FN_BACKSPACE || e.func == gbe_pkg::FN_DELETE ||
                      e.func == gbe_pkg::FN_CLEAR))
        e.func = gbe_pkg::FN_READ;
    end
    return e;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH reply %0d %s: got %0d expected %0d", n_replies, what, got, want);
    n_fail++;
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || awaited_replies.size() != 0) @(posedge clk);
  endtask

  // request side: bursts of random length with random gaps between them
  always @(posedge clk) begin : feed_side
    edit_reply_t reply;
    bit          busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        edit_line(cmd_backlog.pop_front(), reply);
        awaited_replies.push_back(reply);
        n_cmds++;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          in_valid    <= 1'b1;
          in_func     <= cmd_backlog[0].func;
          in_ch       <= cmd_backlog[0].ch;
          in_position <= cmd_backlog[0].position;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reply side: stall pattern that steps through four modes on rx_cycle[7:6], plus one long hold-off
  always @(posedge clk) begin : drain_side
    int rx_cycle;
    int rx_seen;
    int hold_left;
    bit hold_done;
    bit rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle  = 0;
      rx_seen   = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid && out_ready) rx_seen++;
      if (!hold_done && rx_seen >= HOLD_AFTER) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_cycle[7:6])
          2'd0: rdy = 1'b1;
          2'd1: rdy = 1'($urandom_range(0, 1));
          2'd2: rdy = (rx_cycle[1:0] == 2'd0);
          default: rdy = ($urandom_range(0, 9) != 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  // reply checker: compare each reply with the oldest outstanding prediction
  always @(posedge clk) begin : reply_check
    edit_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      n_replies++;
      if (awaited_replies.size() == 0) begin
        flag_mismatch("reply with no request outstanding", 0, 0);
      end else begin
        want = awaited_replies.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", out_status, want.status);
        if (out_cursor !== want.cursor)
          flag_mismatch("cursor", out_cursor, want.cursor);
        if (out_text_length !== want.text_length)
          flag_mismatch("text_length", out_text_length, want.text_length);
        if (out_ch_out !== want.ch_out)
          flag_mismatch("ch_out", out_ch_out, want.ch_out);
      end
    end
  end

  // watchdog: cycles with no request or reply moving
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty line edges, every command, unused codes, range errors
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_READ,      8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_BACKSPACE, 8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_DELETE,    8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_LEFT,      8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_RIGHT,     8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_HOME,      8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_END,       8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_SETCUR,    8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_SETCUR,    8'hFF, 1));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_SPARE_LO,  8'hFF, 511));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_SPARE_HI,  8'hFF, 511));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_INSERT,    8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_INSERT,    8'hFF, 511));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_INSERT,    8'h5A, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_READ,      8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_READ,      8'h00, 2));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_READ,      8'h00, 3));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_READ,      8'h00, 511));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_RIGHT,     8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_LEFT,      8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_LEFT,      8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_BACKSPACE, 8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_DELETE,    8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_SETCUR,    8'h00, 256));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_HOME,      8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_CLEAR,     8'h00, 0));
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_READ,      8'h00, 0));
    wait_drained();

    // fill the store past capacity, so later inserts come back full
    repeat (300) cmd_backlog.push_back(random_cmd(95, 1'b1));
    wait_drained();

    // mixed editing on a long line; the long reply hold-off lands here
    repeat (450) cmd_backlog.push_back(random_cmd(40, 1'b0));
    wait_drained();

    // fresh line, insert heavy again
    cmd_backlog.push_back(cmd_of(gbe_pkg::FN_CLEAR, 8'h00, 0));
    repeat (280) cmd_backlog.push_back(random_cmd(60, 1'b0));
    wait_drained();

    // allow for a stray reply after the last one expected
    repeat (2 * CAP + 8) @(posedge clk);

    $display("%0d requests, %0d replies; longest line %0d of %0d bytes", n_cmds, n_replies,
             peak_len, CAP);
    $display("%0d inserts refused as full, %0d bad positions, %0d reads of text",
             n_full, n_badpos, n_reads);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/gbe_pkg.sv
hdl/gbe_store.sv
hdl/gap_buffer_line_editor_core.sv
hdl/gbe_checker.sv
bench/tb_gap_buffer_line_editor_core.sv
